[rtl/mrs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types, constants and the CRC-16 byte step for the register slave.
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam int REG_COUNT   = 32;
    localparam int FRAME_BYTES = 64;
    localparam int REG_AW      = $clog2(REG_COUNT);
    localparam int FRAME_AW    = $clog2(FRAME_BYTES);

    localparam logic [4:0]  READ_LIMIT_CAP  = 5'd29;
    localparam logic [4:0]  WRITE_LIMIT_CAP = 5'd27;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    // request kinds
    localparam logic [1:0] KIND_RX_BYTE  = 2'd0;
    localparam logic [1:0] KIND_APP_WR   = 2'd1;
    localparam logic [1:0] KIND_APP_RD   = 2'd2;

    // modbus function codes
    localparam logic [7:0] FN_READ_HOLD  = 8'd3;
    localparam logic [7:0] FN_READ_INPUT = 8'd4;
    localparam logic [7:0] FN_WRITE_MULT = 8'd16;
    localparam logic [7:0] FN_EXC_FLAG   = 8'h80;

    // exception codes
    localparam logic [7:0] EXC_ILL_FUNC  = 8'h01;
    localparam logic [7:0] EXC_ILL_ADDR  = 8'h02;

    // frame status
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_ADDR   = 3'd1;
    localparam logic [2:0] ST_CRC_ERR    = 3'd2;
    localparam logic [2:0] ST_ILL_ADDR   = 3'd3;
    localparam logic [2:0] ST_ILL_FUNC   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_SLAVE_ADDR = 3'd0;
    localparam logic [2:0] CFG_READ_BASE  = 3'd1;
    localparam logic [2:0] CFG_READ_MAXQ  = 3'd2;
    localparam logic [2:0] CFG_WRITE_BASE = 3'd3;
    localparam logic [2:0] CFG_WRITE_MAXQ = 3'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [4:0]  reg_index;
        logic [15:0] reg_value;
    } mrs_in_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        byte_valid;
        logic        last_item;
        logic [2:0]  frame_status;
        logic [15:0] read_value;
    } mrs_out_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/modbus_rtu_register_slave_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_register_slave_unit
// Modbus RTU slave with a 32 x 16 holding register file.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_data) carries received line bytes and
// application register reads and writes. Bytes are buffered; the byte flagged
// frame_end starts frame processing. Output channel (m_valid/m_ready/m_data)
// carries reply bytes one per item, or a single status item when no reply is
// sent, or the value of an application read.
// Sequence: buffered bytes and application requests are taken in the idle state.
// At frame end the buffer is scanned one byte a cycle through the RAM read port,
// the check state follows, a write request then writes its registers from the
// buffered high and low bytes, and the reply bytes are emitted while the receiver
// keeps up. The CRC register is shared by scan and reply; each has its own step.
// s_ready is low for the whole frame processing. A receiver stall holds the
// current item in the output register and freezes the sequencer in its sending states.
// Reset clears the frame length, overflow flag and holding registers and sets the
// configuration to its defaults; buffer contents are left as they are.
// ----------------------------------------------------------------------------
module modbus_rtu_register_slave_unit
    import mrs_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire mrs_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output mrs_out_t      m_data,
    input  wire logic     cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [1:0] RPL_EXC = 2'd0;
    localparam logic [1:0] RPL_RD  = 2'd1;
    localparam logic [1:0] RPL_WR  = 2'd2;

    logic [2:0]  state_reg;
    logic [7:0]  slave_addr_reg;
    logic [4:0]  read_base_reg, read_maxq_reg, write_base_reg, write_maxq_reg;
    logic [6:0]  len_reg;
    logic        ovf_reg;
    logic [15:0] hreg_reg [REG_COUNT];
    logic [6:0]  ptr_reg;
    logic        p_valid_reg;
    logic [6:0]  p_idx_reg;
    logic [7:0]  hdr_reg [6];
    logic [7:0]  rx_lo_reg, rx_hi_reg, hi_byte_reg, code_reg;
    logic [15:0] crc_reg;
    logic [1:0]  rpl_reg;
    logic [2:0]  st_reg;
    logic [4:0]  addr_reg, qty_reg, waddr_reg;
    logic [5:0]  e_reg;
    logic        m_valid_reg;
    mrs_out_t    m_data_reg;

    logic        out_free, accept;
    logic [7:0]  ram_q;
    logic        ram_we;
    logic [5:0]  ram_raddr;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign ram_we    = accept && (s_data.kind == KIND_RX_BYTE) && (len_reg < 7'(FRAME_BYTES));
    assign ram_raddr = (state_reg == S_WRITE) ? 6'(ptr_reg + 7'd7) : ptr_reg[5:0];

    mrs_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_frame_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (len_reg[FRAME_AW-1:0]),
        .wdata (s_data.rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    // frame check
    logic [15:0] f_addr, f_qty;
    logic [16:0] f_end;
    logic [17:0] f_wr_len;
    logic        is_rd, is_wr;
    logic [4:0]  base, lim, lim_cfg, lim_cap;
    logic [5:0]  base_lim;
    logic        win_ok;
    logic [2:0]  chk_st;

    always_comb begin
        f_addr   = {hdr_reg[2], hdr_reg[3]};
        f_qty    = {hdr_reg[4], hdr_reg[5]};
        f_end    = {1'b0, f_addr} + {1'b0, f_qty};
        f_wr_len = 18'd9 + {1'b0, f_qty, 1'b0};
        is_rd    = (hdr_reg[1] == FN_READ_HOLD) || (hdr_reg[1] == FN_READ_INPUT);
        is_wr    = (hdr_reg[1] == FN_WRITE_MULT);
        base     = is_rd ? read_base_reg : write_base_reg;
        lim_cfg  = is_rd ? read_maxq_reg : write_maxq_reg;
        lim_cap  = is_rd ? READ_LIMIT_CAP : WRITE_LIMIT_CAP;
        lim      = (lim_cfg > lim_cap) ? lim_cap : lim_cfg;
        base_lim = {1'b0, base} + {1'b0, lim};
        win_ok   = (f_addr >= {11'd0, base}) && (f_qty <= {11'd0, lim})
                && (f_end <= {11'd0, base_lim}) && (f_end <= 17'(REG_COUNT));
        priority if (hdr_reg[0] != slave_addr_reg) begin
            chk_st = ST_NOT_ADDR;
        end else if (ovf_reg || len_reg < 7'd4) begin
            chk_st = ST_CRC_ERR;
        end else if (rx_lo_reg != crc_reg[7:0] || rx_hi_reg != crc_reg[15:8]) begin
            chk_st = ST_CRC_ERR;
        end else if (is_rd && len_reg != 7'd8) begin
            chk_st = ST_CRC_ERR;
        end else if (is_wr && {11'd0, len_reg} != f_wr_len) begin
            chk_st = ST_CRC_ERR;
        end else if (is_rd || is_wr) begin
            chk_st = win_ok ? ST_OK : ST_ILL_ADDR;
        end else begin
            chk_st = ST_ILL_FUNC;
        end
    end

    // reply byte generation
    logic [5:0]  e_off, blen;
    logic [4:0]  rd_idx;
    logic [15:0] rd_word;
    logic [7:0]  body;

    always_comb begin
        e_off   = e_reg - 6'd3;
        rd_idx  = (state_reg == S_EMIT) ? (addr_reg + e_off[5:1]) : s_data.reg_index;
        rd_word = hreg_reg[rd_idx];
        unique case (rpl_reg)
            RPL_RD:  blen = 6'd3 + {qty_reg, 1'b0};
            RPL_WR:  blen = 6'd6;
            default: blen = 6'd3;
        endcase
        body = 8'h00;
        priority if (e_reg == 6'd0) begin
            body = hdr_reg[0];
        end else if (rpl_reg == RPL_WR) begin
            body = (e_reg < 6'd6) ? hdr_reg[e_reg[2:0]] : 8'h00;
        end else if (e_reg == 6'd1) begin
            body = (rpl_reg == RPL_EXC) ? (hdr_reg[1] | FN_EXC_FLAG) : hdr_reg[1];
        end else if (e_reg == 6'd2) begin
            body = (rpl_reg == RPL_EXC) ? code_reg : {2'b00, qty_reg, 1'b0};
        end else begin
            body = e_off[0] ? rd_word[7:0] : rd_word[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            slave_addr_reg <= 8'd1;
            read_base_reg  <= 5'd0;
            read_maxq_reg  <= 5'd16;
            write_base_reg <= 5'd0;
            write_maxq_reg <= 5'd16;
            len_reg        <= 7'd0;
            ovf_reg        <= 1'b0;
            p_valid_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                hreg_reg[i] <= 16'd0;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_SLAVE_ADDR: slave_addr_reg <= cfg_wdata;
                    CFG_READ_BASE:  read_base_reg  <= cfg_wdata[4:0];
                    CFG_READ_MAXQ:  read_maxq_reg  <= cfg_wdata[4:0];
                    CFG_WRITE_BASE: write_base_reg <= cfg_wdata[4:0];
                    CFG_WRITE_MAXQ: write_maxq_reg <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        unique case (s_data.kind)
                            KIND_RX_BYTE: begin
                                if (len_reg < 7'(FRAME_BYTES)) begin
                                    len_reg <= len_reg + 7'd1;
                                end else begin
                                    ovf_reg <= 1'b1;
                                end
                                if (s_data.frame_end) begin
                                    state_reg   <= S_SCAN;
                                    ptr_reg     <= 7'd0;
                                    p_valid_reg <= 1'b0;
                                    crc_reg     <= CRC_INIT;
                                end
                            end
                            KIND_APP_WR: hreg_reg[s_data.reg_index] <= s_data.reg_value;
                            KIND_APP_RD: begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= '{tx_byte: 8'd0, byte_valid: 1'b0,
                                                 last_item: 1'b1, frame_status: ST_OK,
                                                 read_value: rd_word};
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    // read address runs one ahead of the returned data
                    p_valid_reg <= ptr_reg < len_reg;
                    p_idx_reg   <= ptr_reg;
                    if (ptr_reg < len_reg) begin
                        ptr_reg <= ptr_reg + 7'd1;
                    end
                    if (p_valid_reg) begin
                        if (p_idx_reg < 7'd6) begin
                            hdr_reg[p_idx_reg[2:0]] <= ram_q;
                        end
                        if (p_idx_reg + 7'd2 == len_reg) begin
                            rx_lo_reg <= ram_q;
                        end
                        if (p_idx_reg + 7'd2 < len_reg) begin
                            crc_reg <= crc_byte(crc_reg, ram_q);
                        end
                        if (p_idx_reg + 7'd1 == len_reg) begin
                            rx_hi_reg   <= ram_q;
                            p_valid_reg <= 1'b0;
                            state_reg   <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    st_reg    <= chk_st;
                    addr_reg  <= f_addr[4:0];
                    qty_reg   <= f_qty[4:0];
                    waddr_reg <= f_addr[4:0];
                    crc_reg   <= CRC_INIT;
                    e_reg     <= 6'd0;
                    ptr_reg   <= 7'd0;
                    code_reg  <= (chk_st == ST_ILL_ADDR) ? EXC_ILL_ADDR : EXC_ILL_FUNC;
                    rpl_reg   <= (chk_st != ST_OK) ? RPL_EXC : (is_rd ? RPL_RD : RPL_WR);
                    if (chk_st == ST_NOT_ADDR || chk_st == ST_CRC_ERR) begin
                        if (out_free) begin
                            m_valid_reg <= 1'b1;
                            m_data_reg  <= '{tx_byte: 8'd0, byte_valid: 1'b0,
                                             last_item: 1'b1, frame_status: chk_st,
                                             read_value: 16'd0};
                            len_reg     <= 7'd0;
                            ovf_reg     <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                    end else if (chk_st == ST_OK && is_wr && f_qty != 16'd0) begin
                        state_reg <= S_WRITE;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_WRITE: begin
                    p_valid_reg <= ptr_reg < {1'b0, qty_reg, 1'b0};
                    p_idx_reg   <= ptr_reg;
                    if (ptr_reg < {1'b0, qty_reg, 1'b0}) begin
                        ptr_reg <= ptr_reg + 7'd1;
                    end
                    if (p_valid_reg) begin
                        if (!p_idx_reg[0]) begin
                            hi_byte_reg <= ram_q;
                        end else begin
                            hreg_reg[waddr_reg] <= {hi_byte_reg, ram_q};
                            waddr_reg           <= waddr_reg + 5'd1;
                        end
                        if (p_idx_reg + 7'd1 == {1'b0, qty_reg, 1'b0}) begin
                            p_valid_reg <= 1'b0;
                            state_reg   <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        e_reg       <= e_reg + 6'd1;
                        m_data_reg  <= '{tx_byte: body, byte_valid: 1'b1, last_item: 1'b0,
                                         frame_status: st_reg, read_value: 16'd0};
                        priority if (e_reg < blen) begin
                            crc_reg <= crc_byte(crc_reg, body);
                        end else if (e_reg == blen) begin
                            m_data_reg.tx_byte <= crc_reg[7:0];
                        end else begin
                            m_data_reg.tx_byte   <= crc_reg[15:8];
                            m_data_reg.last_item <= 1'b1;
                            len_reg              <= 7'd0;
                            ovf_reg              <= 1'b0;
                            state_reg            <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/mrs_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives request frames, application accesses and noise into the register
// slave and checks every reply byte and status item against a predictor.
// ----------------------------------------------------------------------------
import mrs_pkg::*;

class reply_scoreboard;
    mrs_out_t   pending[$];
    logic [7:0] station;
    logic [4:0] rd_base, rd_lim, wr_base, wr_lim;
    logic [15:0] regs[REG_COUNT];
    logic [7:0] rx_buf[$];
    bit         overrun;
    int         mismatches;

    function void clear();
        pending.delete();
        rx_buf.delete();
        overrun = 0;
        station = 8'd1;
        rd_base = 0;
        rd_lim = 5'd16;
        wr_base = 0;
        wr_lim = 5'd16;
        mismatches = 0;
        foreach (regs[i]) regs[i] = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] v);
        case (idx)
            CFG_SLAVE_ADDR: station = v;
            CFG_READ_BASE:  rd_base = v[4:0];
            CFG_READ_MAXQ:  rd_lim = v[4:0];
            CFG_WRITE_BASE: wr_base = v[4:0];
            CFG_WRITE_MAXQ: wr_lim = v[4:0];
            default: ;
        endcase
    endfunction

    function logic [15:0] crc16(logic [7:0] b[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (b[i]) begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function bit window_fits(int a, int q, int base, int lim, int cap);
        if (lim > cap) lim = cap;
        return a >= base && q <= lim && a + q <= base + lim && a + q <= REG_COUNT;
    endfunction

    function void push_status(logic [2:0] st, logic [15:0] rv);
        mrs_out_t o;
        o = '0;
        o.last_item = 1;
        o.frame_status = st;
        o.read_value = rv;
        pending.push_back(o);
    endfunction

    function void push_reply(logic [7:0] r[$], logic [2:0] st);
        logic [15:0] c;
        mrs_out_t o;
        c = crc16(r);
        r.push_back(c[7:0]);
        r.push_back(c[15:8]);
        foreach (r[i]) begin
            o = '0;
            o.tx_byte = r[i];
            o.byte_valid = 1;
            o.last_item = (i == r.size() - 1);
            o.frame_status = st;
            pending.push_back(o);
        end
    endfunction

    // judge a complete frame
    function void judge_frame();
        logic [7:0] f[$];
        logic [7:0] r[$];
        logic [15:0] c;
        int n, a, q;
        bit rd;
        f = rx_buf;
        n = f.size();
        if (n >= 1 && f[0] != station) begin push_status(ST_NOT_ADDR, 0); return; end
        if (overrun || n < 4) begin push_status(ST_CRC_ERR, 0); return; end
        c = crc16(f[0:n-3]);
        if (f[n-2] != c[7:0] || f[n-1] != c[15:8]) begin
            push_status(ST_CRC_ERR, 0);
            return;
        end
        if (f[1] == FN_READ_HOLD || f[1] == FN_READ_INPUT || f[1] == FN_WRITE_MULT) begin
            rd = f[1] != FN_WRITE_MULT;
            if (rd ? n != 8 : n < 9) begin push_status(ST_CRC_ERR, 0); return; end
            a = {f[2], f[3]};
            q = {f[4], f[5]};
            if (!rd && n != 9 + 2 * q) begin push_status(ST_CRC_ERR, 0); return; end
            if (!(rd ? window_fits(a, q, rd_base, rd_lim, 29)
                     : window_fits(a, q, wr_base, wr_lim, 27))) begin
                r = '{f[0], f[1] | FN_EXC_FLAG, EXC_ILL_ADDR};
                push_reply(r, ST_ILL_ADDR);
                return;
            end
            if (rd) begin
                r = '{f[0], f[1], 8'(2 * q)};
                for (int i = 0; i < q; i++) begin
                    r.push_back(regs[a+i][15:8]);
                    r.push_back(regs[a+i][7:0]);
                end
            end else begin
                for (int i = 0; i < q; i++) regs[a+i] = {f[7+2*i], f[8+2*i]};
                r = f[0:5];
            end
            push_reply(r, ST_OK);
            return;
        end
        r = '{f[0], f[1] | FN_EXC_FLAG, EXC_ILL_FUNC};
        push_reply(r, ST_ILL_FUNC);
    endfunction

    function void note_request(mrs_in_t d);
        case (d.kind)
            KIND_APP_WR: regs[d.reg_index] = d.reg_value;
            KIND_APP_RD: push_status(ST_OK, regs[d.reg_index]);
            KIND_RX_BYTE: begin
                if (rx_buf.size() < FRAME_BYTES) rx_buf.push_back(d.rx_byte);
                else overrun = 1;
                if (d.frame_end) begin
                    judge_frame();
                    rx_buf.delete();
                    overrun = 0;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_reply(mrs_out_t got);
        mrs_out_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.tx_byte !== want.tx_byte || got.byte_valid !== want.byte_valid ||
            got.last_item !== want.last_item || got.frame_status !== want.frame_status ||
            got.read_value !== want.read_value) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected %h actual %h", want, got);
        end
    endfunction
endclass

module tb;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    mrs_in_t     s_data = '0;
    logic        m_valid;
    logic        m_ready = 0;
    mrs_out_t    m_data;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_wdata = '0;

    reply_scoreboard sb;
    bit   calm = 0;
    int   quiet_cycles = 0;
    bit   fail_seen = 0;

    localparam int WATCHDOG = 20000;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    modbus_rtu_register_slave_unit u_top (.*);

    // receiver with random stalls
    always @(negedge aclk) m_ready <= calm || ($urandom_range(99) >= 18);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_reply(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // entered at a falling edge and left at one; valid stays up for a
    // following request and is dropped when idling or waiting
    task automatic send(mrs_in_t d);
        while (!calm && $urandom_range(99) < 18) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(d);
        @(negedge aclk);
    endtask

    task automatic send_byte(logic [7:0] b, bit last);
        mrs_in_t d;
        d = '0;
        d.kind = KIND_RX_BYTE;
        d.rx_byte = b;
        d.frame_end = last;
        d.reg_index = 5'($urandom);
        d.reg_value = 16'($urandom);
        send(d);
    endtask

    task automatic send_frame(logic [7:0] f[$], bit good_crc);
        logic [15:0] c;
        c = sb.crc16(f);
        if (good_crc) begin
            f.push_back(c[7:0]);
            f.push_back(c[15:8]);
        end
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic app_access(logic [1:0] k, logic [4:0] idx, logic [15:0] v);
        mrs_in_t d;
        d = '0;
        d.kind = k;
        d.reg_index = idx;
        d.reg_value = v;
        d.rx_byte = 8'($urandom);
        d.frame_end = 1'($urandom);
        send(d);
    endtask

    task automatic read_req(logic [7:0] st, logic [7:0] fn, logic [15:0] a, logic [15:0] q);
        logic [7:0] f[$];
        f = '{st, fn, a[15:8], a[7:0], q[15:8], q[7:0]};
        send_frame(f, 1);
    endtask

    task automatic write_req(logic [7:0] st, logic [15:0] a, int q, int n_vals);
        logic [7:0] f[$];
        f = '{st, FN_WRITE_MULT, a[15:8], a[7:0], 8'(q >> 8), 8'(q), 8'(2 * q)};
        for (int i = 0; i < 2 * n_vals; i++) f.push_back(8'($urandom));
        send_frame(f, 1);
    endtask

    task automatic drain_then_cfg(logic [2:0] idx, logic [7:0] v);
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_phase(int count);
        logic [7:0] f[$];
        int sel, len, a, q;
        logic [7:0] st;
        for (int i = 0; i < count; i++) begin
            calm = (i >= count / 3 && i < count / 2);
            sel = $urandom_range(99);
            st = ($urandom_range(9) == 0) ? 8'($urandom) : sb.station;
            a = $urandom_range(33);
            q = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            if (sel < 30) read_req(st, $urandom_range(1) ? FN_READ_HOLD : FN_READ_INPUT,
                                   ($urandom_range(19) == 0) ? 16'($urandom) : 16'(a),
                                   ($urandom_range(19) == 0) ? 16'($urandom) : 16'(q));
            else if (sel < 50) write_req(st, 16'(a), q,
                                   ($urandom_range(7) == 0) ? $urandom_range(3) : q);
            else if (sel < 60) app_access(KIND_APP_WR, 5'($urandom), 16'($urandom));
            else if (sel < 72) app_access(KIND_APP_RD, 5'($urandom), 16'($urandom));
            else if (sel < 80) begin
                f = '{st, 8'($urandom)};
                send_frame(f, 1);
            end else if (sel < 90) begin
                len = $urandom_range(1, 12);
                f.delete();
                for (int k = 0; k < len; k++) f.push_back(8'($urandom));
                if ($urandom_range(1)) f[0] = sb.station;
                send_frame(f, 1'($urandom_range(1)));
            end else if (sel < 93) begin
                len = $urandom_range(60, 70);
                f = '{sb.station};
                for (int k = 1; k < len; k++) f.push_back(8'($urandom));
                send_frame(f, 1);
            end else begin
                f = '{st, FN_READ_HOLD, 8'(a), 8'(q)};
                send_frame(f, 0);
            end
        end
        calm = 0;
    endtask

    initial begin
        logic [7:0] f[$];
        sb = new();
        sb.clear();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // directed: extremes, every function and each failure status
        app_access(KIND_APP_WR, 5'd0, 16'hFFFF);
        app_access(KIND_APP_WR, 5'd31, 16'h8001);
        app_access(KIND_APP_RD, 5'd31, 16'h0);
        app_access(KIND_APP_RD, 5'd0, 16'hFFFF);
        read_req(8'd1, FN_READ_HOLD, 16'd0, 16'd16);
        read_req(8'd1, FN_READ_INPUT, 16'd0, 16'd0);
        read_req(8'd1, FN_READ_HOLD, 16'd1, 16'd16);
        read_req(8'd1, FN_READ_HOLD, 16'hFFFF, 16'hFFFF);
        write_req(8'd1, 16'd0, 3, 3);
        write_req(8'd1, 16'd0, 0, 0);
        write_req(8'd1, 16'd15, 2, 2);
        write_req(8'd1, 16'd0, 2, 1);
        read_req(8'd2, FN_READ_HOLD, 16'd0, 16'd1);
        f = '{8'd1, 8'd6, 8'd0, 8'd0, 8'd0, 8'd1};
        send_frame(f, 1);
        f = '{8'd1, 8'hFF, 8'hAA};
        send_frame(f, 0);
        f = '{8'd1, FN_READ_HOLD, 8'd0, 8'd0, 8'd0, 8'd1, 8'h00, 8'h00};
        send_frame(f, 0);

        drain_then_cfg(CFG_SLAVE_ADDR, 8'd247);
        drain_then_cfg(CFG_READ_BASE, 8'd0);
        drain_then_cfg(CFG_READ_MAXQ, 8'd31);
        drain_then_cfg(CFG_WRITE_BASE, 8'd0);
        drain_then_cfg(CFG_WRITE_MAXQ, 8'd31);
        // long stretch with no idling on either side
        calm = 1;
        write_req(8'd247, 16'd0, 27, 27);
        read_req(8'd247, FN_READ_HOLD, 16'd0, 16'd29);
        read_req(8'd247, FN_READ_HOLD, 16'd0, 16'd30);
        calm = 0;
        random_phase(8);

        drain_then_cfg(CFG_SLAVE_ADDR, 8'd1);
        drain_then_cfg(CFG_READ_BASE, 8'd31);
        drain_then_cfg(CFG_READ_MAXQ, 8'd0);
        drain_then_cfg(CFG_WRITE_BASE, 8'd31);
        drain_then_cfg(CFG_WRITE_MAXQ, 8'd1);
        random_phase(6);

        drain_then_cfg(CFG_SLAVE_ADDR, 8'($urandom_range(1, 247)));
        drain_then_cfg(CFG_READ_BASE, 8'd4);
        drain_then_cfg(CFG_READ_MAXQ, 8'd12);
        drain_then_cfg(CFG_WRITE_BASE, 8'd8);
        drain_then_cfg(CFG_WRITE_MAXQ, 8'd20);
        random_phase(6);

        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        fail_seen = sb.mismatches != 0 || sb.pending.size() != 0;
        if (!fail_seen)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
